@@ hdl/plr_pkg.sv @@
// ----------------------------------------------------------------------------
// plr_pkg
// Shared types and constants of the patterned line rasterizer.
// ----------------------------------------------------------------------------
package plr_pkg;

  // coordinate and datapath widths
  localparam int COORD_BITS = 12;
  localparam int ERR_BITS   = COORD_BITS + 3;

  // style pattern constants
  localparam int DOT_PERIOD = 5;
  localparam int DOT_BITS   = 3;
  localparam int DASH_ON    = 5;
  localparam int DASH_WRAP  = 10;
  localparam int DASH_BITS  = 4;

  // configuration port
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = CFG_ADDR_BITS - 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_STYLE = '0;

  // line style codes
  localparam logic [1:0] STYLE_SOLID  = 2'd0;
  localparam logic [1:0] STYLE_DOTTED = 2'd1;
  localparam logic [1:0] STYLE_DASHED = 2'd2;

  // item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  // input beat
  typedef struct packed {
    logic                         kind;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;
  } in_item_t;

  // result beat
  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         visible;
    logic                         last_pixel;
  } out_item_t;

  // handshake status from the stepper back to the input stage
  typedef struct packed {
    logic take;
    logic res_vld;
  } core_stat_t;

endpackage

@@ hdl/plr_core.sv @@
// ----------------------------------------------------------------------------
// plr_core
// Line setup and per-pixel Bresenham stepping with style pattern and
// result register.
// ----------------------------------------------------------------------------
module plr_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_vld,
  input  plr_pkg::in_item_t item,
  input  logic [1:0]       style,
  input  logic             out_stall,
  output plr_pkg::core_stat_t stat,
  output plr_pkg::out_item_t  res
);
  import plr_pkg::*;

  localparam int C = COORD_BITS;

  // line state
  logic [C-1:0]         cur_x_r, cur_x_nxt;
  logic [C-1:0]         cur_y_r, cur_y_nxt;
  logic [ERR_BITS-1:0]  err_r, err_nxt;
  logic [C-1:0]         major_r, major_nxt;
  logic [C-1:0]         minor_r, minor_nxt;
  logic [C-1:0]         step_r, step_nxt;
  logic                 xneg_r, xneg_nxt;
  logic                 yneg_r, yneg_nxt;
  logic                 swap_r, swap_nxt;
  logic                 active_r, active_nxt;
  logic [DASH_BITS-1:0] dash_r, dash_nxt;
  logic [DOT_BITS-1:0]  dot_r, dot_nxt;
  out_item_t            res_r, res_nxt;
  logic                 res_vld_r, res_vld_nxt;

  logic                 is_step, emits, out_free, take;
  logic [C:0]           dx, dy, adx_w, ady_w;
  logic [C-1:0]         adx, ady, ld_major, ld_minor;
  logic                 ld_swap;
  logic                 last, err_ge0, inc_x, inc_y, vis;
  logic [C-1:0]         sx, sy;

  // handshake
  assign is_step  = (item.kind == KIND_STEP);
  assign emits    = is_step && active_r;
  assign out_free = !res_vld_r || !out_stall;
  assign take     = item_vld && (!emits || out_free);

  // load setup: deltas, magnitudes, axis choice
  assign dx      = {item.x_end[C-1], item.x_end} - {item.x_start[C-1], item.x_start};
  assign dy      = {item.y_end[C-1], item.y_end} - {item.y_start[C-1], item.y_start};
  assign adx_w   = dx[C] ? (~dx + 1'b1) : dx;
  assign ady_w   = dy[C] ? (~dy + 1'b1) : dy;
  assign adx     = adx_w[C-1:0];
  assign ady     = ady_w[C-1:0];
  assign ld_swap = ady > adx;
  assign ld_major = ld_swap ? ady : adx;
  assign ld_minor = ld_swap ? adx : ady;

  // step decision
  assign last    = step_r >= major_r;
  assign err_ge0 = !err_r[ERR_BITS-1];
  assign inc_x   = swap_r ? err_ge0 : 1'b1;
  assign inc_y   = swap_r ? 1'b1 : err_ge0;
  assign sx      = xneg_r ? {C{1'b1}} : C'(1);
  assign sy      = yneg_r ? {C{1'b1}} : C'(1);

  // style pattern
  always_comb begin
    case (style)
      STYLE_DOTTED: vis = (dot_r == '0);
      STYLE_DASHED: vis = (dash_r < DASH_BITS'(DASH_ON));
      default:      vis = 1'b1;
    endcase
  end

  // next state
  always_comb begin
    cur_x_nxt   = cur_x_r;
    cur_y_nxt   = cur_y_r;
    err_nxt     = err_r;
    major_nxt   = major_r;
    minor_nxt   = minor_r;
    step_nxt    = step_r;
    xneg_nxt    = xneg_r;
    yneg_nxt    = yneg_r;
    swap_nxt    = swap_r;
    active_nxt  = active_r;
    dash_nxt    = dash_r;
    dot_nxt     = dot_r;
    res_nxt     = res_r;
    res_vld_nxt = res_vld_r && out_stall;
    if (take && !is_step) begin
      cur_x_nxt  = item.x_start;
      cur_y_nxt  = item.y_start;
      xneg_nxt   = dx[C];
      yneg_nxt   = dy[C];
      swap_nxt   = ld_swap;
      major_nxt  = ld_major;
      minor_nxt  = ld_minor;
      err_nxt    = {2'b00, ld_minor, 1'b0} - {3'b000, ld_major};
      step_nxt   = '0;
      dash_nxt   = '0;
      dot_nxt    = '0;
      active_nxt = 1'b1;
    end else if (take && emits) begin
      res_nxt.pixel_x    = cur_x_r;
      res_nxt.pixel_y    = cur_y_r;
      res_nxt.visible    = vis;
      res_nxt.last_pixel = last;
      res_vld_nxt        = 1'b1;
      if (style == STYLE_DASHED) begin
        dash_nxt = (dash_r == DASH_BITS'(DASH_WRAP)) ? '0 : dash_r + 1'b1;
      end
      if (last) begin
        active_nxt = 1'b0;
      end else begin
        if (inc_x) cur_x_nxt = cur_x_r + sx;
        if (inc_y) cur_y_nxt = cur_y_r + sy;
        err_nxt  = err_r + {2'b00, minor_r, 1'b0}
                   - (err_ge0 ? {2'b00, major_r, 1'b0} : '0);
        step_nxt = step_r + 1'b1;
        dot_nxt  = (dot_r == DOT_BITS'(DOT_PERIOD - 1)) ? '0 : dot_r + 1'b1;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      res_vld_r <= 1'b0;
      dash_r    <= '0;
      dot_r     <= '0;
    end else begin
      active_r  <= active_nxt;
      res_vld_r <= res_vld_nxt;
      dash_r    <= dash_nxt;
      dot_r     <= dot_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    cur_x_r <= cur_x_nxt;
    cur_y_r <= cur_y_nxt;
    err_r   <= err_nxt;
    major_r <= major_nxt;
    minor_r <= minor_nxt;
    step_r  <= step_nxt;
    xneg_r  <= xneg_nxt;
    yneg_r  <= yneg_nxt;
    swap_r  <= swap_nxt;
    res_r   <= res_nxt;
  end

  assign stat.take    = take;
  assign stat.res_vld = res_vld_r;
  assign res          = res_r;

endmodule

@@ hdl/patterned_line_rasterizer_top.sv @@
// ----------------------------------------------------------------------------
// patterned_line_rasterizer_top
// Bresenham line stepper for all octants with solid, dotted and dashed styles.
// ----------------------------------------------------------------------------
// The block takes one beat per clock and gives one pixel per clock while the
// receiver does not stall. A load beat sets up a line and gives no result;
// each step beat on a loaded line gives one pixel, from the start point to
// the end point inclusive, with last_pixel on the end point. A beat passes
// an input register and then the setup/step logic into the result register,
// from which its pixel goes out. The input register lets one more beat in
// while a result waits for the receiver; in_stall rises only when that beat
// still holds a step on a loaded line and the result register is blocked.
// line_style is written over the APB port at byte address 0; the user must
// write it only while the block is idle, the block itself does not enforce it.
// ----------------------------------------------------------------------------
module patterned_line_rasterizer_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  plr_pkg::in_item_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output plr_pkg::out_item_t                 out_data,
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [plr_pkg::CFG_ADDR_BITS-1:0]  cfg_paddr,
  input  logic [plr_pkg::CFG_DATA_BITS-1:0]  cfg_pwdata,
  output logic [plr_pkg::CFG_DATA_BITS-1:0]  cfg_prdata,
  output logic                               cfg_pready
);
  import plr_pkg::*;

  logic [1:0]              line_style_r, line_style_nxt;
  in_item_t                item_r, item_nxt;
  logic                    item_vld_r, item_vld_nxt;
  core_stat_t              stat;
  logic [CFG_IDX_BITS-1:0] cfg_idx;
  logic                    cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    line_style_nxt = line_style_r;
    if (cfg_wr && (cfg_idx == REG_LINE_STYLE)) begin
      line_style_nxt = cfg_pwdata[1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_idx == REG_LINE_STYLE) begin
      cfg_prdata = {{(CFG_DATA_BITS-2){1'b0}}, line_style_r};
    end
  end

  // input register
  assign in_stall = item_vld_r && !stat.take;

  always_comb begin
    item_nxt     = item_r;
    item_vld_nxt = item_vld_r && !stat.take;
    if (in_valid && !in_stall) begin
      item_nxt     = in_data;
      item_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_style_r <= STYLE_SOLID;
      item_vld_r   <= 1'b0;
    end else begin
      line_style_r <= line_style_nxt;
      item_vld_r   <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  // stepper and result register
  plr_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_vld  (item_vld_r),
    .item      (item_r),
    .style     (line_style_r),
    .out_stall (out_stall),
    .stat      (stat),
    .res       (out_data)
  );

  assign out_valid = stat.res_vld;

endmodule

@@ hdl/plr_checker.sv @@
// ----------------------------------------------------------------------------
// plr_checker
// Port-level checks of the patterned line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module plr_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input plr_pkg::in_item_t                 in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input plr_pkg::out_item_t                out_data,
  input logic                              cfg_psel,
  input logic                              cfg_penable,
  input logic                              cfg_pwrite,
  input logic [plr_pkg::CFG_ADDR_BITS-1:0] cfg_paddr,
  input logic [plr_pkg::CFG_DATA_BITS-1:0] cfg_pwdata,
  input logic [plr_pkg::CFG_DATA_BITS-1:0] cfg_prdata,
  input logic                              cfg_pready
);
  import plr_pkg::*;

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("input beat changed while stalled");

  // a blocked result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input is held back only by a blocked result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  // line_style reads back what was written
  a_style_readback: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
      && (cfg_paddr[CFG_ADDR_BITS-1:2] == REG_LINE_STYLE)
    |=> (cfg_paddr[CFG_ADDR_BITS-1:2] != REG_LINE_STYLE)
      || (cfg_prdata == {{(CFG_DATA_BITS-2){1'b0}}, $past(cfg_pwdata[1:0])}))
    else $error("line_style readback mismatch");

endmodule

bind patterned_line_rasterizer_top plr_checker u_plr_checker (.*);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the patterned line rasterizer.
// ----------------------------------------------------------------------------
// Line loads and pixel steps are queued by the stimulus process and sent by a
// clocked driver. Each accepted beat goes through a line tracer here that
// mirrors the Bresenham stepper and the style pattern. A clocked monitor
// compares every pixel beat with the oldest traced pixel. The line style is
// changed between phases over the APB port, and each phase uses its own mix
// of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import plr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 8;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 140;
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));

  localparam logic [1:0] STYLE_SPARE = 2'd3;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_STYLE = {REG_LINE_STYLE, 2'b00};
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_SPARE = {~REG_LINE_STYLE, 2'b00};

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_item_t                 in_data = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_item_t                out_data;
  logic                     cfg_psel = 1'b0;
  logic                     cfg_penable = 1'b0;
  logic                     cfg_pwrite = 1'b0;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr = '0;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  // beats waiting to be sent and pixels waiting to come out
  in_item_t  items_to_send[$];
  out_item_t expected_pixels[$];

  int pixel_errors = 0;
  int cycle_cnt = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int queued_cnt = 0;

  // mirror of the line stepper
  logic [1:0] style_q = STYLE_SOLID;
  int         pos_x = 0;
  int         pos_y = 0;
  int         decision = 0;
  int         run_len = 0;
  int         rise_len = 0;
  int         pix_idx = 0;
  bit         x_neg = 1'b0;
  bit         y_neg = 1'b0;
  bit         y_major = 1'b0;
  bit         drawing = 1'b0;
  int         dash_phase = 0;

  // per-phase style word and handshake pressure
  logic [CFG_DATA_BITS-1:0] style_word[PHASES] = '{
    {30'd0, STYLE_DOTTED},
    {30'd0, STYLE_DASHED},
    {30'd0, STYLE_SOLID},
    {30'h2AAA_AAAA, STYLE_DASHED},
    {30'd0, STYLE_SPARE},
    {30'h3FFF_FFFF, STYLE_DOTTED},
    {30'd0, STYLE_DASHED},
    {30'd0, STYLE_SOLID}
  };
  int phase_send_idle[PHASES] = '{0, 80, 0, 9, 80, 0, 9, 0};
  int phase_recv_stall[PHASES] = '{0, 0, 80, 9, 0, 80, 9, 0};

  patterned_line_rasterizer_top dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // style pattern for the pixel about to go out
  function automatic bit pattern_on();
    bit on;
    on = 1'b1;
    if (style_q == STYLE_DOTTED) begin
      on = (pix_idx % DOT_PERIOD) == 0;
    end else if (style_q == STYLE_DASHED) begin
      if (dash_phase < DASH_ON) begin
        on = 1'b1;
        dash_phase++;
      end else if (dash_phase < DASH_WRAP) begin
        on = 1'b0;
        dash_phase++;
      end else begin
        on = 1'b0;
        dash_phase = 0;
      end
    end
    return on;
  endfunction

  // set up a line or emit its current pixel and move on
  function automatic void trace_line(in_item_t it);
    int        dx;
    int        dy;
    bit        at_end;
    out_item_t px;
    if (it.kind == KIND_LOAD) begin
      dx = int'(it.x_end) - int'(it.x_start);
      dy = int'(it.y_end) - int'(it.y_start);
      x_neg = dx < 0;
      y_neg = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      y_major = dy > dx;
      run_len = y_major ? dy : dx;
      rise_len = y_major ? dx : dy;
      decision = 2 * rise_len - run_len;
      pos_x = it.x_start;
      pos_y = it.y_start;
      pix_idx = 0;
      dash_phase = 0;
      drawing = 1'b1;
    end else if (drawing) begin
      at_end = pix_idx >= run_len;
      px.pixel_x = pos_x[COORD_BITS-1:0];
      px.pixel_y = pos_y[COORD_BITS-1:0];
      px.visible = pattern_on();
      px.last_pixel = at_end;
      expected_pixels.push_back(px);
      if (at_end) begin
        drawing = 1'b0;
      end else begin
        if (decision >= 0) begin
          if (y_major) pos_x += x_neg ? -1 : 1;
          else pos_y += y_neg ? -1 : 1;
          decision -= 2 * run_len;
        end
        if (y_major) pos_y += y_neg ? -1 : 1;
        else pos_x += x_neg ? -1 : 1;
        decision += 2 * rise_len;
        pix_idx++;
      end
    end
  endfunction

  // driver: hold a stalled beat, otherwise send the next one or idle
  always @(posedge clk) begin : driver
    bit took;
    took = in_valid && !in_stall;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (took) begin
        trace_line(in_data);
        void'(items_to_send.pop_front());
      end
      if (took || !in_valid) begin
        if (items_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= items_to_send[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check each pixel beat against the oldest traced pixel
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          pixel_errors++;
          if (pixel_errors <= 10)
            $display("unexpected pixel: x=%0d y=%0d vis=%0b last=%0b",
                     out_data.pixel_x, out_data.pixel_y, out_data.visible,
                     out_data.last_pixel);
        end else begin
          want = expected_pixels.pop_front();
          if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
              out_data.visible !== want.visible ||
              out_data.last_pixel !== want.last_pixel) begin
            pixel_errors++;
            if (pixel_errors <= 10)
              $display("pixel mismatch: exp x=%0d y=%0d vis=%0b last=%0b,",
                       want.pixel_x, want.pixel_y, want.visible, want.last_pixel,
                       " got x=%0d y=%0d vis=%0b last=%0b",
                       out_data.pixel_x, out_data.pixel_y, out_data.visible,
                       out_data.last_pixel);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // APB write: setup cycle, then access until pready
  task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] addr,
                           input logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr[CFG_ADDR_BITS-1:2] == REG_LINE_STYLE) style_q = data[1:0];
  endtask

  // wait until every beat is sent and every pixel is back, then settle
  task automatic drain();
    while (items_to_send.size() != 0 || expected_pixels.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  function automatic int rand_coord();
    int v;
    v = $urandom_range(0, COORD_MAX - COORD_MIN);
    return v + COORD_MIN;
  endfunction

  // end point at base+d, mirrored or clamped to stay in range
  function automatic int fit_coord(int base, int d);
    int v;
    v = base + d;
    if (v > COORD_MAX || v < COORD_MIN) v = base - d;
    if (v > COORD_MAX) v = COORD_MAX;
    if (v < COORD_MIN) v = COORD_MIN;
    return v;
  endfunction

  function automatic void push_load(int x0, int y0, int x1, int y1);
    in_item_t it;
    it.kind = KIND_LOAD;
    it.x_start = x0[COORD_BITS-1:0];
    it.y_start = y0[COORD_BITS-1:0];
    it.x_end = x1[COORD_BITS-1:0];
    it.y_end = y1[COORD_BITS-1:0];
    items_to_send.push_back(it);
  endfunction

  // step beats carry junk coordinates, which the block ignores
  function automatic void push_steps(int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      it.kind = KIND_STEP;
      it.x_start = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      it.y_start = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      it.x_end = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      it.y_end = COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
      items_to_send.push_back(it);
    end
  endfunction

  // corner points, zero length, steps with no line, lines in both x directions
  task automatic queue_directed();
    push_steps(1);
    push_load(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
    push_steps(2);
    push_load(COORD_MAX, COORD_MAX, COORD_MAX - 4, COORD_MAX - 2);
    push_steps(5);
    push_load(COORD_MIN, COORD_MAX, COORD_MIN + 3, COORD_MAX - 5);
    push_steps(6);
    push_load(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
    push_steps(3);
  endtask

  // mostly whole short lines, some cut short or overrun, some noise
  task automatic queue_random();
    int x0, y0, x1, y1, dx, dy, span, n_step, pick;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      push_steps(1);
      queued_cnt++;
    end else if (pick < 8) begin
      push_load(rand_coord(), rand_coord(), rand_coord(), rand_coord());
      queued_cnt++;
    end else begin
      x0 = rand_coord();
      y0 = rand_coord();
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        dx = 0;
        dy = 0;
      end else if (pick < 82) begin
        dx = $urandom_range(0, 48) - 24;
        dy = $urandom_range(0, 48) - 24;
      end else if (pick < 95) begin
        dx = $urandom_range(0, 200) - 100;
        dy = $urandom_range(0, 200) - 100;
      end else begin
        dx = rand_coord() - x0;
        dy = rand_coord() - y0;
      end
      // flat, vertical and diagonal lines
      case ($urandom_range(0, 9))
        0: dy = 0;
        1: dx = 0;
        2: dy = $urandom_range(0, 1) ? dx : -dx;
        default: ;
      endcase
      x1 = fit_coord(x0, dx);
      y1 = fit_coord(y0, dy);
      dx = (x1 > x0) ? x1 - x0 : x0 - x1;
      dy = (y1 > y0) ? y1 - y0 : y0 - y1;
      span = (dx > dy) ? dx : dy;
      pick = $urandom_range(0, 99);
      if (span > 60) n_step = (pick < 25 && span <= 200) ? span + 1 : $urandom_range(1, 40);
      else if (pick < 75) n_step = span + 1;
      else if (pick < 85) n_step = span + 1 + $urandom_range(1, 2);
      else n_step = $urandom_range(0, span);
      push_load(x0, y0, x1, y1);
      push_steps(n_step);
      queued_cnt += 1 + n_step;
    end
  endtask

  // reset, directed lines, then random phases over styles and pressure
  initial begin : stimulus
    int k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    queue_directed();
    drain();
    for (k = 0; k < PHASES; k++) begin
      write_reg(ADDR_STYLE, style_word[k]);
      // writes to an unmapped register must not change the style
      if (k == PHASES - 2) write_reg(ADDR_SPARE, ~style_word[k]);
      send_idle_pct = phase_send_idle[k];
      recv_stall_pct = phase_recv_stall[k];
      queued_cnt = 0;
      while (queued_cnt < PHASE_ITEMS) queue_random();
      drain();
    end
    if (pixel_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
